>>> rtl/core/quaternion_nlerp_blend_core_defines.svh
// ----------------------------------------------------------------------------
// quaternion_nlerp_blend_core_defines
// assertion macros used by the port checker, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NLERP_BLEND_CORE_DEFINES_SVH
`define QUATERNION_NLERP_BLEND_CORE_DEFINES_SVH

// checked only while out of reset
`define QNB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define QNB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/qnb_pkg.sv
// ----------------------------------------------------------------------------
// qnb_pkg
// types and widths for the quaternion nlerp blend core
// ----------------------------------------------------------------------------
`default_nettype none

package qnb_pkg;

  localparam int COMP_N   = 4;
  localparam int DATA_W   = 32;
  localparam int WT_W     = 17;
  localparam int FRAC_W   = 16;
  localparam int HALF_LSB = 1 << (FRAC_W - 1);
  localparam int AB_W     = 2 * DATA_W;
  localparam int DOT_W    = AB_W + 2;
  localparam int PROD_W   = DATA_W + WT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int MAG_W    = DATA_W;
  localparam int LZ_W     = $clog2(MAG_W);
  localparam int V_W      = 30;
  localparam int SQ_W     = 2 * V_W;
  localparam int LEN_W    = SQ_W + 2;
  localparam int ROOT_W   = LEN_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CUR_W    = REM_W + 2;
  localparam int Q_W      = FRAC_W + 1;
  localparam int NUM_W    = V_W + Q_W;

  localparam logic [WT_W-1:0]   WT_ONE  = WT_W'(1 << FRAC_W);
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [LZ_W-1:0]   V_MSB   = LZ_W'(V_W - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic signed [DATA_W-1:0] b_w;
    logic [WT_W-1:0]          weight;
    logic                     is_rotation;
  } qnb_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
  } qnb_out_t;

  typedef struct packed {
    logic                           rot;
    logic                           zero;
    logic [COMP_N-1:0]              neg;
    logic [COMP_N-1:0][DATA_W-1:0]  val;
  } qnb_side_t;

endpackage

`default_nettype wire

>>> rtl/core/qnb_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// qnb_sqrt_pipe
// pipelined integer square root, one root bit per stage, sideband carried along
// ----------------------------------------------------------------------------
`default_nettype none

module qnb_sqrt_pipe import qnb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [LEN_W-1:0]  in_len,
  input  qnb_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output qnb_side_t         out_side
);

  logic [ROOT_W:0]       vld_r;
  logic [LEN_W-1:0]      len_r  [ROOT_W+1];
  logic [REM_W-1:0]      rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]     root_r [ROOT_W+1];
  qnb_side_t             side_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0]  <= in_len;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int BI = ROOT_W - 1 - k;
    logic [CUR_W-1:0]  cur;
    logic [CUR_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      cur      = {rem_r[k], len_r[k][2*BI+1:2*BI]};
      trial    = CUR_W'({root_r[k], 2'b01});
      ge       = (cur >= trial);
      rem_nxt  = ge ? REM_W'(cur - trial) : REM_W'(cur);
      root_nxt = {root_r[k][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k+1]  <= len_r[k];
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

`default_nettype wire

>>> rtl/core/qnb_div_pipe.sv
// ----------------------------------------------------------------------------
// qnb_div_pipe
// pipelined restoring divide of each component by the length, one bit a stage
// ----------------------------------------------------------------------------
`default_nettype none

module qnb_div_pipe import qnb_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ROOT_W-1:0]            in_root,
  input  qnb_side_t                    in_side,
  output logic                         out_valid,
  output logic [COMP_N-1:0][Q_W-1:0]   out_quo,
  output qnb_side_t                    out_side
);

  logic [Q_W:0]                       vld_r;
  logic [COMP_N-1:0][NUM_W-1:0]       num_r [Q_W+1];
  logic [COMP_N-1:0][ROOT_W-1:0]      rem_r [Q_W+1];
  logic [COMP_N-1:0][Q_W-1:0]         q_r   [Q_W+1];
  logic [ROOT_W-1:0]                  div_r [Q_W+1];
  qnb_side_t                          side_r[Q_W+1];
  logic [COMP_N-1:0][NUM_W-1:0]       num_nxt;

  // numerator is v * 2^16 plus half the divisor for round to nearest
  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      num_nxt[c] = NUM_W'({in_side.val[c][V_W-1:0], FRAC_W'(0)})
                 + NUM_W'(in_root[ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= num_nxt;
      div_r[0]  <= in_root;
      q_r[0]    <= '0;
      side_r[0] <= in_side;
      for (int c = 0; c < COMP_N; c++) begin
        rem_r[0][c] <= ROOT_W'(num_nxt[c][NUM_W-1:Q_W]);
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int BI = Q_W - 1 - k;
    logic [COMP_N-1:0][ROOT_W:0]   cur;
    logic [COMP_N-1:0]             ge;
    logic [COMP_N-1:0][ROOT_W-1:0] rem_nxt;
    logic [COMP_N-1:0][Q_W-1:0]    q_nxt;

    always_comb begin
      for (int c = 0; c < COMP_N; c++) begin
        cur[c]     = {rem_r[k][c], num_r[k][c][BI]};
        ge[c]      = (cur[c] >= {1'b0, div_r[k]});
        rem_nxt[c] = ge[c] ? ROOT_W'(cur[c] - {1'b0, div_r[k]}) : cur[c][ROOT_W-1:0];
        q_nxt[c]   = {q_r[k][c][Q_W-2:0], ge[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k+1]  <= num_r[k];
        rem_r[k+1]  <= rem_nxt;
        q_r[k+1]    <= q_nxt;
        div_r[k+1]  <= div_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[Q_W];
  assign out_quo   = q_r[Q_W];
  assign out_side  = side_r[Q_W];

endmodule

`default_nettype wire

>>> rtl/core/quaternion_nlerp_blend_core.sv
// ----------------------------------------------------------------------------
// quaternion_nlerp_blend_core
// normalized linear blend of two Q16.16 four-vectors, quaternion or translation
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one request per element: vectors a and b,
//   a Q1.16 weight toward b and the is_rotation flag. out_valid/out_stall/
//   out_data return one blended vector per request, in request order.
//   the pipeline holds six arithmetic stages, 32 in the square root, 18 in the
//   divider and the output register. throughput is one request per cycle while
//   no stalled result is held; the whole pipeline advances as one.
//   while out_valid is high and out_stall is high, every stage holds and
//   in_stall is raised, so nothing is lost or repeated.
//   synchronous active-low reset clears all valid bits; no result is pending
//   after reset and payload registers keep whatever they held.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_nlerp_blend_core import qnb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qnb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qnb_out_t out_data
);

  logic en;
  logic out_valid_r;
  qnb_out_t out_data_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 1: clamp weight, a.b products
  logic signed [DATA_W-1:0] a_in [COMP_N];
  logic signed [DATA_W-1:0] b_in [COMP_N];
  logic [WT_W-1:0]          w_in;
  logic signed [AB_W-1:0]   ab_nxt [COMP_N];

  assign a_in[0] = in_data.a_x;
  assign a_in[1] = in_data.a_y;
  assign a_in[2] = in_data.a_z;
  assign a_in[3] = in_data.a_w;
  assign b_in[0] = in_data.b_x;
  assign b_in[1] = in_data.b_y;
  assign b_in[2] = in_data.b_z;
  assign b_in[3] = in_data.b_w;
  assign w_in    = (in_data.weight > WT_ONE) ? WT_ONE : in_data.weight;

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      ab_nxt[c] = a_in[c] * b_in[c];
    end
  end

  logic                     s1_v_r;
  logic                     s1_rot_r;
  logic signed [DATA_W-1:0] s1_a_r [COMP_N];
  logic signed [DATA_W-1:0] s1_b_r [COMP_N];
  logic [WT_W-1:0]          s1_w_r;
  logic [WT_W-1:0]          s1_omw_r;
  logic signed [AB_W-1:0]   s1_ab_r [COMP_N];

  // stage 2: dot sign, weighted products
  logic signed [DOT_W-1:0]  dot;
  logic signed [PROD_W-1:0] pa_nxt [COMP_N];
  logic signed [PROD_W-1:0] pb_nxt [COMP_N];

  always_comb begin
    dot = DOT_W'(s1_ab_r[0]) + DOT_W'(s1_ab_r[1]) + DOT_W'(s1_ab_r[2]) + DOT_W'(s1_ab_r[3]);
    for (int c = 0; c < COMP_N; c++) begin
      pa_nxt[c] = s1_a_r[c] * $signed({1'b0, s1_omw_r});
      pb_nxt[c] = s1_b_r[c] * $signed({1'b0, s1_w_r});
    end
  end

  logic                     s2_v_r;
  logic                     s2_rot_r;
  logic                     s2_flip_r;
  logic signed [PROD_W-1:0] s2_pa_r [COMP_N];
  logic signed [PROD_W-1:0] s2_pb_r [COMP_N];

  // stage 3: blend and round to Q16.16
  logic signed [SUM_W-1:0] t_sum [COMP_N];
  logic [SUM_W-1:0]        t_abs [COMP_N];
  logic [SUM_W-1:0]        t_rnd [COMP_N];
  logic [MAG_W-1:0]        mag_nxt [COMP_N];
  logic [COMP_N-1:0]       neg_nxt;

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      t_sum[c]   = s2_flip_r ? (SUM_W'(s2_pa_r[c]) - SUM_W'(s2_pb_r[c]))
                             : (SUM_W'(s2_pa_r[c]) + SUM_W'(s2_pb_r[c]));
      t_abs[c]   = t_sum[c][SUM_W-1] ? SUM_W'(-t_sum[c]) : SUM_W'(t_sum[c]);
      t_rnd[c]   = t_abs[c] + SUM_W'(HALF_LSB);
      mag_nxt[c] = t_rnd[c][FRAC_W+MAG_W-1:FRAC_W];
      neg_nxt[c] = t_sum[c][SUM_W-1] && (mag_nxt[c] != '0);
    end
  end

  logic              s3_v_r;
  logic              s3_rot_r;
  logic [MAG_W-1:0]  s3_mag_r [COMP_N];
  logic [COMP_N-1:0] s3_neg_r;

  // stage 4: largest magnitude, saturated translation value
  logic [MAG_W-1:0]  max01;
  logic [MAG_W-1:0]  max23;
  logic [MAG_W-1:0]  max_nxt;
  logic [DATA_W-1:0] tval_nxt [COMP_N];

  always_comb begin
    max01   = (s3_mag_r[0] > s3_mag_r[1]) ? s3_mag_r[0] : s3_mag_r[1];
    max23   = (s3_mag_r[2] > s3_mag_r[3]) ? s3_mag_r[2] : s3_mag_r[3];
    max_nxt = (max01 > max23) ? max01 : max23;
    for (int c = 0; c < COMP_N; c++) begin
      if (s3_neg_r[c]) begin
        tval_nxt[c] = -s3_mag_r[c];
      end else if (s3_mag_r[c][MAG_W-1]) begin
        tval_nxt[c] = SAT_MAX;
      end else begin
        tval_nxt[c] = s3_mag_r[c];
      end
    end
  end

  logic              s4_v_r;
  logic              s4_rot_r;
  logic [MAG_W-1:0]  s4_m_r;
  logic [MAG_W-1:0]  s4_mag_r [COMP_N];
  logic [COMP_N-1:0] s4_neg_r;
  logic [DATA_W-1:0] s4_tval_r [COMP_N];

  // stage 5: common shift so the largest lands in [2^29, 2^30)
  logic [LZ_W-1:0]  msb_pos;
  logic [MAG_W-1:0] shifted [COMP_N];
  qnb_side_t        side5_nxt;

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (s4_m_r[i]) begin
        msb_pos = LZ_W'(i);
      end
    end
    side5_nxt.rot  = s4_rot_r;
    side5_nxt.zero = (s4_m_r == '0);
    side5_nxt.neg  = s4_neg_r;
    for (int c = 0; c < COMP_N; c++) begin
      if (msb_pos > V_MSB) begin
        shifted[c] = s4_mag_r[c] >> (msb_pos - V_MSB);
      end else begin
        shifted[c] = s4_mag_r[c] << (V_MSB - msb_pos);
      end
      side5_nxt.val[c] = s4_rot_r ? DATA_W'(shifted[c][V_W-1:0]) : s4_tval_r[c];
    end
  end

  logic      s5_v_r;
  qnb_side_t s5_side_r;

  // stage 6: squares
  logic [SQ_W-1:0] sq_nxt [COMP_N];

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      sq_nxt[c] = s5_side_r.val[c][V_W-1:0] * s5_side_r.val[c][V_W-1:0];
    end
  end

  logic            s6_v_r;
  qnb_side_t       s6_side_r;
  logic [SQ_W-1:0] s6_sq_r [COMP_N];
  logic [LEN_W-1:0] len_sum;

  assign len_sum = LEN_W'(s6_sq_r[0]) + LEN_W'(s6_sq_r[1])
                 + LEN_W'(s6_sq_r[2]) + LEN_W'(s6_sq_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rot_r  <= in_data.is_rotation;
      s1_w_r    <= w_in;
      s1_omw_r  <= WT_ONE - w_in;
      s2_rot_r  <= s1_rot_r;
      s2_flip_r <= s1_rot_r && dot[DOT_W-1];
      s3_rot_r  <= s2_rot_r;
      s3_neg_r  <= neg_nxt;
      s4_rot_r  <= s3_rot_r;
      s4_m_r    <= max_nxt;
      s4_neg_r  <= s3_neg_r;
      s5_side_r <= side5_nxt;
      s6_side_r <= s5_side_r;
      for (int c = 0; c < COMP_N; c++) begin
        s1_a_r[c]    <= a_in[c];
        s1_b_r[c]    <= b_in[c];
        s1_ab_r[c]   <= ab_nxt[c];
        s2_pa_r[c]   <= pa_nxt[c];
        s2_pb_r[c]   <= pb_nxt[c];
        s3_mag_r[c]  <= mag_nxt[c];
        s4_mag_r[c]  <= s3_mag_r[c];
        s4_tval_r[c] <= tval_nxt[c];
        s6_sq_r[c]   <= sq_nxt[c];
      end
    end
  end

  // length and per-component divide
  logic              sqrt_valid;
  logic [ROOT_W-1:0] sqrt_root;
  qnb_side_t         sqrt_side;

  qnb_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_v_r),
    .in_len    (len_sum),
    .in_side   (s6_side_r),
    .out_valid (sqrt_valid),
    .out_root  (sqrt_root),
    .out_side  (sqrt_side)
  );

  logic                       div_valid;
  logic [COMP_N-1:0][Q_W-1:0] div_quo;
  qnb_side_t                  div_side;

  qnb_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sqrt_valid),
    .in_root   (sqrt_root),
    .in_side   (sqrt_side),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // output register
  logic [DATA_W-1:0] res [COMP_N];
  qnb_out_t          out_nxt;

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      if (!div_side.rot) begin
        res[c] = div_side.val[c];
      end else if (div_side.zero) begin
        res[c] = '0;
      end else if (div_side.neg[c]) begin
        res[c] = -DATA_W'(div_quo[c]);
      end else begin
        res[c] = DATA_W'(div_quo[c]);
      end
    end
    out_nxt.out_x = res[0];
    out_nxt.out_y = res[1];
    out_nxt.out_z = res[2];
    out_nxt.out_w = res[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/qnb_port_checker.sv
// ----------------------------------------------------------------------------
// qnb_port_checker
// port-level checks on the quaternion nlerp blend core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_nlerp_blend_core_defines.svh"

module qnb_port_checker import qnb_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input qnb_out_t out_data
);

  // held result stays put
  `QNB_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // input only backs up behind a stalled result
  `QNB_ASSERT_RST(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held result")

  // no result right after reset
  `QNB_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "result pending after reset")

endmodule

bind quaternion_nlerp_blend_core qnb_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
